FILE: sv/dchb_pkg.sv
// Shared constants, command types and arithmetic helpers of the dual-channel biquad high-pass unit.
package dchb_pkg;

  // Cascade size and index widths.
  localparam int SECTIONS = 2;
  localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  // Field and arithmetic widths.
  localparam int SAMPLE_W  = 24;
  localparam int OUT_W     = 32;
  localparam int DLY_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 30;
  localparam int MULB_W    = 33;
  localparam int PROD_W    = COEF_W + MULB_W;
  localparam int WIDE_W    = 80;
  localparam int ACC_W     = 52;
  localparam int CNT_W     = 12;
  localparam int STEP_W    = 5;

  // Sequencer steps for one section of one channel.
  localparam int STEPS_PER_SEC = 23;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_PER_SEC - 1);

  localparam logic [CNT_W-1:0] WARMUP_RESET = 12'd600;

  // Datapath operation codes.
  localparam logic [2:0] OP_NOP  = 3'd0;
  localparam logic [2:0] OP_MLO  = 3'd1;
  localparam logic [2:0] OP_MHI  = 3'd2;
  localparam logic [2:0] OP_MRG  = 3'd3;
  localparam logic [2:0] OP_ACC  = 3'd4;
  localparam logic [2:0] OP_SETY = 3'd5;
  localparam logic [2:0] OP_WD1  = 3'd6;
  localparam logic [2:0] OP_WD2  = 3'd7;

  // Coefficient selects within one set.
  localparam logic [2:0] COEF_B0 = 3'd0;
  localparam logic [2:0] COEF_B1 = 3'd1;
  localparam logic [2:0] COEF_B2 = 3'd2;
  localparam logic [2:0] COEF_A1 = 3'd3;
  localparam logic [2:0] COEF_A2 = 3'd4;

  // Accumulator base selects.
  localparam logic [1:0] BASE_ACC  = 2'd0;
  localparam logic [1:0] BASE_D1   = 2'd1;
  localparam logic [1:0] BASE_D2   = 2'd2;
  localparam logic [1:0] BASE_ZERO = 2'd3;

  typedef logic [SEC_W-1:0] sec_idx_t;

  localparam sec_idx_t SEC_LAST = SEC_W'(SECTIONS - 1);

  // Command from the controller to the datapath, one per cycle.
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] coef;
    logic       opnd_y;
    logic [1:0] base;
    logic       chan;
    sec_idx_t   sec;
    logic       first_sec;
    logic       last_sec;
    logic       load_sample;
    logic       push;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Q2.30 coefficients; the a terms are stored negated.
  function automatic logic signed [COEF_W-1:0] coef_q30(input logic set,
                                                       input logic [2:0] sel);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (!set) begin
      case (sel)
        COEF_B0: c = 32'sd1061453439;
        COEF_B1: c = -32'sd2122884115;
        COEF_B2: c = 32'sd1061453439;
        COEF_A1: c = 32'sd2122416608;
        COEF_A2: c = -32'sd1049632508;
        default: c = '0;
      endcase
    end else begin
      case (sel)
        COEF_B0: c = 32'sd1044863999;
        COEF_B1: c = -32'sd2089724069;
        COEF_B2: c = 32'sd1044863999;
        COEF_A1: c = 32'sd2089263970;
        COEF_A2: c = -32'sd1016446273;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

  // Saturate an accumulator value to the signed 48-bit state range.
  function automatic logic signed [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DLY_W:0] upper;
    logic signed [DLY_W-1:0] r;
    upper = v[ACC_W-1:DLY_W-1];
    if ((&upper) || !(|upper)) begin
      r = v[DLY_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DLY_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Round a state value to an integer (half up) and saturate to 32 bits.
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [DLY_W-1:0] y);
    logic [DLY_W:0] rnd;
    logic [DLY_W-FRAC_W:0] r;
    logic signed [OUT_W-1:0] o;
    rnd = {y[DLY_W-1], y} + (DLY_W+1)'(32768);
    r   = rnd[DLY_W:FRAC_W];
    if (r[DLY_W-FRAC_W] == r[OUT_W-1]) begin
      o = r[OUT_W-1:0];
    end else if (r[DLY_W-FRAC_W]) begin
      o = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      o = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return o;
  endfunction

endpackage

FILE: sv/dchb_if.sv
// Valid/ready channel interfaces of the dual-channel biquad high-pass unit.
interface dchb_in_if;
  import dchb_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_in;
  logic [SAMPLE_W-1:0] ir_in;
  modport source (output valid, output red_in, output ir_in, input ready);
  modport sink (input valid, input red_in, input ir_in, output ready);
endinterface

interface dchb_out_if;
  import dchb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] red_out;
  logic signed [OUT_W-1:0] ir_out;
  modport source (output valid, output red_out, output ir_out, input ready);
  modport sink (input valid, input red_out, input ir_out, output ready);
endinterface

interface dchb_cfg_if;
  import dchb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] warmup_count;
  modport source (output valid, output warmup_count, input ready);
  modport sink (input valid, input warmup_count, output ready);
endinterface

FILE: sv/dchb_datapath.sv
// Datapath: shared multiply-accumulate unit, biquad delay registers and result registers.
module dchb_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dchb_pkg::dp_cmd_t                cmd_i,
  output dchb_pkg::dp_stat_t               stat_o,
  input  logic [dchb_pkg::SAMPLE_W-1:0]    red_in_i,
  input  logic [dchb_pkg::SAMPLE_W-1:0]    ir_in_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [dchb_pkg::OUT_W-1:0] red_out_o,
  output logic signed [dchb_pkg::OUT_W-1:0] ir_out_o
);
  import dchb_pkg::*;

  logic [SAMPLE_W-1:0]      red_smp_q, ir_smp_q, smp;
  logic signed [DLY_W-1:0]  x_q, y_q, x_cur, opnd;
  logic signed [DLY_W-1:0]  dly_q [2][SECTIONS][2];
  logic signed [DLY_W-1:0]  d1, d2;
  logic [MULB_W-1:0]        mul_b;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [WIDE_W-1:0] part_q;
  logic signed [ACC_W-1:0]  acc_q, acc_base, rnd_prod;
  logic signed [OUT_W-1:0]  res_q [2];
  logic signed [OUT_W-1:0]  red_out_q, ir_out_q;
  logic                     out_valid_q;

  // Operand selection: the first section takes the raw sample in state format.
  always_comb begin
    smp   = cmd_i.chan ? ir_smp_q : red_smp_q;
    x_cur = cmd_i.first_sec ? $signed({8'b0, smp, {FRAC_W{1'b0}}}) : x_q;
    opnd  = cmd_i.opnd_y ? y_q : x_cur;
    d1    = dly_q[cmd_i.chan][cmd_i.sec][0];
    d2    = dly_q[cmd_i.chan][cmd_i.sec][1];
  end

  // One 32x33 partial product per cycle: low 16 bits first, then the signed upper part.
  always_comb begin
    if (cmd_i.op == OP_MHI) begin
      mul_b = {opnd[DLY_W-1], opnd[DLY_W-1:FRAC_W]};
    end else begin
      mul_b = {{(MULB_W-FRAC_W){1'b0}}, opnd[FRAC_W-1:0]};
    end
    coef   = coef_q30(cmd_i.sec[0], cmd_i.coef);
    prod_d = PROD_W'(coef) * PROD_W'($signed(mul_b));
  end

  // Accumulator base and the rounded product taken from the wide register.
  always_comb begin
    case (cmd_i.base)
      BASE_ACC:  acc_base = acc_q;
      BASE_D1:   acc_base = ACC_W'(d1);
      BASE_D2:   acc_base = ACC_W'(d2);
      BASE_ZERO: acc_base = '0;
      default:   acc_base = '0;
    endcase
    rnd_prod = ACC_W'($signed(part_q[WIDE_W-1:COEF_FRAC]));
  end

  // Product, merge and accumulate registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MLO || cmd_i.op == OP_MHI) begin
      prod_q <= prod_d;
    end
    if (cmd_i.op == OP_MHI) begin
      part_q <= WIDE_W'(prod_q) + (WIDE_W'(1) <<< (COEF_FRAC - 1));
    end else if (cmd_i.op == OP_MRG) begin
      part_q <= part_q + (WIDE_W'(prod_q) <<< FRAC_W);
    end
    if (cmd_i.op == OP_ACC) begin
      acc_q <= acc_base + rnd_prod;
    end
    if (cmd_i.op == OP_SETY) begin
      y_q <= sat48(acc_q);
    end
    if (cmd_i.op == OP_WD2) begin
      x_q <= y_q;
      if (cmd_i.last_sec) begin
        res_q[cmd_i.chan] <= to_out(y_q);
      end
    end
    if (cmd_i.load_sample) begin
      red_smp_q <= red_in_i;
      ir_smp_q  <= ir_in_i;
    end
    if (cmd_i.push) begin
      red_out_q <= res_q[0];
      ir_out_q  <= res_q[1];
    end
  end

  // Filter delays, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int s = 0; s < SECTIONS; s++) begin
          dly_q[c][s][0] <= '0;
          dly_q[c][s][1] <= '0;
        end
      end
    end else if (cmd_i.op == OP_WD1) begin
      dly_q[cmd_i.chan][cmd_i.sec][0] <= sat48(acc_q);
    end else if (cmd_i.op == OP_WD2) begin
      dly_q[cmd_i.chan][cmd_i.sec][1] <= sat48(acc_q);
    end
  end

  // Output register: holds one result transaction until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign red_out_o       = red_out_q;
  assign ir_out_o        = ir_out_q;

endmodule

FILE: sv/dchb_ctrl.sv
// Controller: warm-up bookkeeping and the step sequencer that drives the datapath.
module dchb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dchb_pkg::CNT_W-1:0]    cfg_warmup_i,
  input  dchb_pkg::dp_stat_t            stat_i,
  output dchb_pkg::dp_cmd_t             cmd_o
);
  import dchb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  sec_idx_t          sec_q, sec_d;
  logic              chan_q, chan_d;
  logic [CNT_W-1:0]  pass_q, pass_d;
  logic              emit_q, emit_d;
  logic              warm_q, warm_d;
  logic [CNT_W-1:0]  wcount_q;
  logic              in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  // Per-section micro-sequence: five rounded products, each low part, high part,
  // merge and accumulate, with writes of y and d1 between them and of d2 after the last.
  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = OP_NOP;
    cmd_o.coef        = COEF_B0;
    cmd_o.base        = BASE_ACC;
    cmd_o.chan        = chan_q;
    cmd_o.sec         = sec_q;
    cmd_o.first_sec   = (sec_q == '0);
    cmd_o.last_sec    = (sec_q == SEC_LAST);
    cmd_o.load_sample = in_fire;
    cmd_o.push        = (state_q == ST_PUSH) && stat_i.out_free;
    if (state_q == ST_RUN) begin
      case (step_q)
        5'd0:  begin cmd_o.op = OP_MLO; cmd_o.coef = COEF_B0; end
        5'd1:  begin cmd_o.op = OP_MHI; cmd_o.coef = COEF_B0; end
        5'd2:  cmd_o.op = OP_MRG;
        5'd3:  begin cmd_o.op = OP_ACC; cmd_o.base = BASE_D1; end
        5'd4:  cmd_o.op = OP_SETY;
        5'd5:  begin cmd_o.op = OP_MLO; cmd_o.coef = COEF_B1; end
        5'd6:  begin cmd_o.op = OP_MHI; cmd_o.coef = COEF_B1; end
        5'd7:  cmd_o.op = OP_MRG;
        5'd8:  begin cmd_o.op = OP_ACC; cmd_o.base = BASE_D2; end
        5'd9:  begin cmd_o.op = OP_MLO; cmd_o.coef = COEF_A1; cmd_o.opnd_y = 1'b1; end
        5'd10: begin cmd_o.op = OP_MHI; cmd_o.coef = COEF_A1; cmd_o.opnd_y = 1'b1; end
        5'd11: cmd_o.op = OP_MRG;
        5'd12: begin cmd_o.op = OP_ACC; cmd_o.base = BASE_ACC; end
        5'd13: cmd_o.op = OP_WD1;
        5'd14: begin cmd_o.op = OP_MLO; cmd_o.coef = COEF_B2; end
        5'd15: begin cmd_o.op = OP_MHI; cmd_o.coef = COEF_B2; end
        5'd16: cmd_o.op = OP_MRG;
        5'd17: begin cmd_o.op = OP_ACC; cmd_o.base = BASE_ZERO; end
        5'd18: begin cmd_o.op = OP_MLO; cmd_o.coef = COEF_A2; cmd_o.opnd_y = 1'b1; end
        5'd19: begin cmd_o.op = OP_MHI; cmd_o.coef = COEF_A2; cmd_o.opnd_y = 1'b1; end
        5'd20: cmd_o.op = OP_MRG;
        5'd21: begin cmd_o.op = OP_ACC; cmd_o.base = BASE_ACC; end
        5'd22: cmd_o.op = OP_WD2;
        default: cmd_o.op = OP_NOP;
      endcase
    end
  end

  // State machine: accept, run the passes over both channels, hand over the result (none in warm-up).
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sec_d   = sec_q;
    chan_d  = chan_q;
    pass_d  = pass_q;
    emit_d  = emit_q;
    warm_d  = warm_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          step_d = '0;
          sec_d  = '0;
          chan_d = 1'b0;
          if (warm_q) begin
            pass_d  = CNT_W'(1);
            emit_d  = 1'b1;
            state_d = ST_RUN;
          end else if (wcount_q == '0) begin
            warm_d = 1'b1;
          end else begin
            pass_d  = wcount_q;
            emit_d  = 1'b0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          step_d = '0;
          if (sec_q == SEC_LAST) begin
            sec_d = '0;
            if (chan_q) begin
              chan_d = 1'b0;
              if (pass_q == CNT_W'(1)) begin
                if (emit_q) begin
                  state_d = ST_PUSH;
                end else begin
                  warm_d  = 1'b1;
                  state_d = ST_IDLE;
                end
              end else begin
                pass_d = pass_q - CNT_W'(1);
              end
            end else begin
              chan_d = 1'b1;
            end
          end else begin
            sec_d = sec_q + SEC_W'(1);
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_PUSH: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      sec_q    <= '0;
      chan_q   <= 1'b0;
      pass_q   <= '0;
      emit_q   <= 1'b0;
      warm_q   <= 1'b0;
      wcount_q <= WARMUP_RESET;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
      chan_q  <= chan_d;
      pass_q  <= pass_d;
      emit_q  <= emit_d;
      warm_q  <= warm_d;
      if (cfg_valid_i) begin
        wcount_q <= cfg_warmup_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_LAST))
    else $error("sequencer step beyond the last section step");

  a_pass_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pass_q != '0))
    else $error("running with no pass left");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (stat_i.out_free && emit_q))
    else $error("result pushed into a full output register or during warm-up");

  a_warm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(warm_q))
    else $error("warm-up flag cleared outside reset");
`endif

endmodule

FILE: sv/dual_channel_biquad_highpass_unit.sv
// Top level of the dual-channel biquad high-pass unit.
//
// Usage:
//   in_i carries one red/infrared photocurrent pair per transaction; out_o
//   returns one high-pass filtered, saturated pair per transaction; cfg_i
//   writes warmup_count, to be done only while the unit is idle.
//   The first transaction after reset is run warmup_count times through both
//   cascades and gives no result; every later transaction gives one result.
// Sequencing:
//   One pass over both channels runs every section of each channel in turn on the
//   single shared 32x33 multiplier: each Q2.30 product is two partial products, low
//   and high, then a merge and an accumulate; five products per section and channel.
//   A normal transaction's result enters the output register as the unit returns
//   to idle, so it can be taken in the same cycle in which the next transaction is
//   accepted; a new transaction is accepted only while the unit is idle.
// Reset and stall:
//   Reset clears all filter delays and the warm-up flag and sets warmup_count
//   to 600. A result waits in the output register while the receiver stalls;
//   the next transaction is still accepted and computed, and the unit then
//   holds its result until the output register is free.
module dual_channel_biquad_highpass_unit (
  input logic        clk_i,
  input logic        rst_ni,
  dchb_cfg_if.sink   cfg_i,
  dchb_in_if.sink    in_i,
  dchb_out_if.source out_o
);
  import dchb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  dchb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_ready_o  (cfg_i.ready),
    .cfg_warmup_i (cfg_i.warmup_count),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Arithmetic and storage.
  dchb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .red_in_i    (in_i.red_in),
    .ir_in_i     (in_i.ir_in),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .red_out_o   (out_o.red_out),
    .ir_out_o    (out_o.ir_out)
  );

endmodule
